// ===== rtl/ogsf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogsf_pkg
// Shared constants and types for the occupancy grid shape fill block.
// ----------------------------------------------------------------------------
package ogsf_pkg;

    localparam int MAX_COLUMNS = 512;
    localparam int MAX_ROWS    = 256;

    localparam logic [9:0] GRID_WIDTH_RESET  = 10'd300;
    localparam logic [8:0] GRID_HEIGHT_RESET = 9'd200;

    localparam logic [1:0] KIND_POINT = 2'd0;
    localparam logic [1:0] KIND_RECT  = 2'd1;
    localparam logic [1:0] KIND_CIRC  = 2'd2;
    localparam logic [1:0] KIND_READ  = 2'd3;

    localparam logic [0:0] REG_WIDTH  = 1'd0;
    localparam logic [0:0] REG_HEIGHT = 1'd1;

    // square root request and answer between top level and root unit
    typedef struct packed {
        logic        start;
        logic [23:0] value;
    } t_sqrt_req;

    typedef struct packed {
        logic        done;
        logic [11:0] root;
    } t_sqrt_rsp;

endpackage

// ===== rtl/ogsf_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogsf_sqrt
// Rounded integer square root, one result bit resolved per cycle.
// ----------------------------------------------------------------------------
module ogsf_sqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ogsf_pkg::t_sqrt_req i_req,
    output ogsf_pkg::t_sqrt_rsp o_rsp
);

    logic [25:0] r_rem, n_rem;
    logic [23:0] r_val;
    logic [24:0] r_res, n_res;
    logic [24:0] r_bit, n_bit;
    logic        r_busy;
    logic        r_done;
    logic [24:0] w_round;
    logic [25:0] w_sum;
    logic [11:0] r_root_q;

    // one digit of the restoring root recurrence
    always_comb begin
        w_sum = {1'b0, r_res} + {1'b0, r_bit};
        if (r_rem >= w_sum) begin
            n_rem = r_rem - w_sum;
            n_res = (r_res >> 1) + r_bit;
        end else begin
            n_rem = r_rem;
            n_res = r_res >> 1;
        end
        n_bit = r_bit >> 2;
    end

    // round up when n exceeds s*s+s, i.e. remainder exceeds s
    assign w_round = (r_rem > {1'b0, r_res}) ? r_res + 25'd1 : r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rem  <= {2'd0, i_req.value};
                r_val  <= i_req.value;
                r_res  <= 25'd0;
                r_bit  <= 25'h0400000;
            end else if (r_busy) begin
                if (r_bit == 25'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_rem <= n_rem;
                    r_res <= n_res;
                    r_bit <= n_bit;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = (r_val == 24'd0) ? 12'd0 : r_root_q;

    always_ff @(posedge i_clk) begin
        r_root_q <= w_round[11:0];
    end

endmodule

// ===== rtl/occupancy_grid_shape_fill.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_shape_fill
// One-bit occupancy grid with point, rectangle and circle fill and cell read.
// ----------------------------------------------------------------------------
// Commands arrive on the s_axis channel; tdata packs kind, pos_x, pos_y,
// extent_x and extent_y. Each command gives one result transfer on m_axis
// carrying the read bit and the echoed kind. Columns and rows in use are to be
// set over APB (register 0 width at 0x0, register 1 height at 0x4) only while
// idle, which the block itself does not enforce. One command is worked at a
// time; the grid memory writes one cell per cycle. A read goes through the
// registered memory read; a point fills one cell; a rectangle fills its rows
// one clipped span at a time; a circle takes a square root per row pair
// (radius plus one of them) and fills its 2*r rows. A rectangle or circle of
// nonpositive size fills nothing. The block goes back to idle on loading the result.
// After reset a clearing pass writes one cell per cycle over the whole memory
// of 2**(column bits + row bits) cells (131072 by default), during
// which no command is taken.
// A stalled result holds in the output register; one more command may be
// worked meanwhile, and its result waits until the register is free.
// ----------------------------------------------------------------------------
module occupancy_grid_shape_fill #(
    parameter int MAX_COLUMNS = ogsf_pkg::MAX_COLUMNS,
    parameter int MAX_ROWS    = ogsf_pkg::MAX_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // kind[1:0], pos_x[13:2], pos_y[25:14], extent_x[37:26], extent_y[49:38]
    input  logic [55:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // occupied[0], kind_done[2:1]
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_COLUMNS) > 0 ? $clog2(MAX_COLUMNS) : 1;
    localparam int RW = $clog2(MAX_ROWS) > 0 ? $clog2(MAX_ROWS) : 1;
    localparam int AW = CW + RW;
    localparam int DEPTH = 1 << AW;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_ROW   = 4'd2;
    localparam logic [3:0] ST_CELL  = 4'd3;
    localparam logic [3:0] ST_SQRT  = 4'd4;
    localparam logic [3:0] ST_SWAIT = 4'd5;
    localparam logic [3:0] ST_RD    = 4'd6;
    localparam logic [3:0] ST_RD2   = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    logic [3:0]  r_state;
    logic [9:0]  r_gw;
    logic [8:0]  r_gh;
    logic [1:0]  r_kind;
    logic signed [13:0] r_px, r_py, r_ex, r_ey;
    logic signed [13:0] r_i;           // row counter for fills
    logic        r_lower;              // circle: second row of the pair
    logic signed [13:0] r_y, r_x, r_x1;
    logic [AW:0] r_clr;
    logic        r_occ;
    logic        r_oocc;
    logic        r_ovalid;
    logic [1:0]  r_okind;
    logic        w_out_load;
    logic        w_cell_ok;

    logic        mem [DEPTH];
    logic        r_mem_q;
    logic        w_we;
    logic [AW-1:0] w_waddr, w_raddr;

    logic [13:0] w_clim, w_rlim;
    ogsf_pkg::t_sqrt_req w_sreq;
    ogsf_pkg::t_sqrt_rsp w_srsp;
    logic [11:0] r_m;
    logic signed [13:0] w_x0, w_x1;
    logic signed [23:0] w_ex_wide, w_i_wide, w_sq;

    assign pready = 1'b1;
    assign w_clim = (r_gw < 10'(MAX_COLUMNS)) || (MAX_COLUMNS > 1023) ? 14'(r_gw)
                                                                      : 14'(MAX_COLUMNS);
    assign w_rlim = (r_gh < 9'(MAX_ROWS)) || (MAX_ROWS > 511) ? 14'(r_gh) : 14'(MAX_ROWS);

    // register read back
    always_comb begin
        prdata = 32'd0;
        case (paddr[2])
            ogsf_pkg::REG_WIDTH:  prdata = {22'd0, r_gw};
            ogsf_pkg::REG_HEIGHT: prdata = {23'd0, r_gh};
            default:              prdata = 32'd0;
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_okind, r_oocc};
    assign w_out_load    = (r_state == ST_OUT) && (!r_ovalid || m_axis_tready);

    // span of the current row, clipped to columns in use
    always_comb begin
        if (r_kind == ogsf_pkg::KIND_CIRC) begin
            w_x0 = r_px - $signed({2'd0, r_m});
            w_x1 = r_px + $signed({2'd0, r_m});
        end else if (r_kind == ogsf_pkg::KIND_RECT) begin
            w_x0 = r_px;
            w_x1 = r_px + r_ex;
        end else begin
            w_x0 = r_px;
            w_x1 = r_px + 14'sd1;
        end
        if (w_x0 < 0) w_x0 = 14'sd0;
        if (w_x1 > $signed(w_clim)) w_x1 = $signed(w_clim);
    end

    // r*r - dy*dy for the current circle row
    assign w_ex_wide = 24'(r_ex);
    assign w_i_wide  = 24'(r_i);
    assign w_sq      = w_ex_wide * w_ex_wide - w_i_wide * w_i_wide;

    assign w_sreq.start = (r_state == ST_SQRT);
    assign w_sreq.value = w_sq;

    ogsf_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_sreq),
        .o_rsp  (w_srsp)
    );

    // the current cell lies on a row in use and inside the span
    assign w_cell_ok = (r_y >= 0) && (r_y < $signed(w_rlim)) && (r_x < r_x1);

    assign w_we    = (r_state == ST_CLEAR) || ((r_state == ST_CELL) && w_cell_ok);
    assign w_waddr = (r_state == ST_CLEAR) ? r_clr[AW-1:0]
                                           : {r_y[RW-1:0], r_x[CW-1:0]};
    assign w_raddr = {r_py[RW-1:0], r_px[CW-1:0]};

    // grid memory, one write and one read each cycle
    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= (r_state == ST_CELL);
        r_mem_q <= mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_gw     <= ogsf_pkg::GRID_WIDTH_RESET;
            r_gh     <= ogsf_pkg::GRID_HEIGHT_RESET;
        end else begin
            if (psel && penable && pwrite) begin
                case (paddr[2])
                    ogsf_pkg::REG_WIDTH:  if (paddr[1:0] == 2'd0) r_gw <= pwdata[9:0];
                    ogsf_pkg::REG_HEIGHT: if (paddr[1:0] == 2'd0) r_gh <= pwdata[8:0];
                    default: ;
                endcase
            end
            // load the output register when free or leaving, else drop on transfer
            if (w_out_load) begin
                r_ovalid <= 1'b1;
                r_okind  <= r_kind;
                r_oocc   <= r_occ;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(DEPTH - 1)) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_kind <= s_axis_tdata[1:0];
                        r_px   <= 14'(signed'(s_axis_tdata[13:2]));
                        r_py   <= 14'(signed'(s_axis_tdata[25:14]));
                        r_ex   <= 14'(signed'(s_axis_tdata[37:26]));
                        r_ey   <= 14'(signed'(s_axis_tdata[49:38]));
                        r_i    <= 14'sd0;
                        r_lower <= 1'b0;
                        r_occ  <= 1'b0;
                        r_state <= ST_ROW;
                        if (s_axis_tdata[1:0] == ogsf_pkg::KIND_READ) r_state <= ST_RD;
                        else if (s_axis_tdata[1:0] == ogsf_pkg::KIND_CIRC)
                            r_state <= ST_SQRT;
                    end
                end
                ST_RD:  r_state <= ST_RD2;
                ST_RD2: begin
                    r_occ <= (r_px >= 0) && (r_py >= 0) && (r_px < $signed(w_clim))
                             && (r_py < $signed(w_rlim)) && r_mem_q;
                    r_state <= ST_OUT;
                end
                ST_SQRT: r_state <= ST_SWAIT;
                ST_SWAIT: begin
                    // hold the half-width for both rows of the pair
                    if (w_srsp.done) begin
                        r_m     <= w_srsp.root;
                        r_state <= ST_ROW;
                    end
                end
                ST_ROW: begin
                    // set up the next row or finish
                    if ((r_kind == ogsf_pkg::KIND_POINT && r_i != 0) ||
                        (r_kind == ogsf_pkg::KIND_RECT &&
                         (r_ex <= 0 || r_ey <= 0 || r_i >= r_ey)) ||
                        (r_kind == ogsf_pkg::KIND_CIRC && (r_ex <= 0 || r_i >= r_ex))) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_y  <= (r_kind == ogsf_pkg::KIND_CIRC && r_lower)
                                ? r_py - 14'sd1 - r_i : r_py + r_i;
                        r_x  <= w_x0;
                        r_x1 <= w_x1;
                        r_state <= ST_CELL;
                    end
                end
                ST_CELL: begin
                    // rows outside range, empty spans and the last cell advance
                    if (!w_cell_ok || (r_x + 14'sd1 >= r_x1)) begin
                        if (r_kind == ogsf_pkg::KIND_CIRC && !r_lower) begin
                            r_lower <= 1'b1;
                            r_state <= ST_ROW;
                        end else begin
                            r_lower <= 1'b0;
                            r_i     <= r_i + 14'sd1;
                            r_state <= (r_kind == ogsf_pkg::KIND_CIRC) ? ST_SQRT : ST_ROW;
                        end
                    end else begin
                        r_x <= r_x + 14'sd1;
                    end
                end
                ST_OUT: begin
                    if (w_out_load) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
